>>> hw/rtl/mqmh_pkg.sv
// Shared types and codes for the multi-queue minimum-head merge block.
// Holds the request and result word layouts, request and status codes,
// configuration register indexes and the scan control bundle. No dependencies.
`default_nettype none

package mqmh_pkg;

  localparam int NUM_QUEUES  = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int ITEM_WIDTH  = 32;

  localparam int QIDX_W    = 2;
  localparam int REQ_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;
  localparam int COUNT_MAX = 127;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [REQ_W-1:0] REQ_PUT    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_GET    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTHING  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 1'd1;

  typedef struct packed {
    logic [REQ_W-1:0]      req_type;
    logic [QIDX_W-1:0]     queue_index;
    logic [ITEM_WIDTH-1:0] data_in;
  } request_t;

  typedef struct packed {
    logic [ITEM_WIDTH-1:0] data_out;
    logic [QIDX_W-1:0]     source_queue;
    logic [STATUS_W-1:0]   status;
    logic [COUNT_W-1:0]    total_count;
    logic                  all_empty;
  } result_t;

  typedef struct packed {
    logic              clear;
    logic              take;
    logic [QIDX_W-1:0] q;
  } scan_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/multi_queue_min_head_merge_top.sv
// Top level of the multi-queue minimum-head merge block: ring FIFOs in one
// item memory, pointer and count registers, and the request sequencer.
// Depends on mqmh_pkg and mqmh_min_unit.
`default_nettype none

// A request word is taken when start is high and busy is low; its result word
// appears on result with done high for exactly one cycle and must be taken
// then. A put or a clear goes from IDLE straight to REPORT; a get or a
// remove passes through SCAN and POP first, since the queue heads are
// read one per cycle through the single read port of the item memory and
// judged by one shared comparator. busy stays high until the result cycle,
// and a new word may be started in the cycle that done is high.
// Configuration writes are taken at once and belong to idle periods.
module multi_queue_min_head_merge_top #(
  parameter int QUEUE_DEPTH = mqmh_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  mqmh_pkg::request_t                 request,
  output logic                               done,
  output mqmh_pkg::result_t                  result,
  input  logic                               cfg_we,
  input  logic [mqmh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mqmh_pkg::CFG_W-1:0]         cfg_data
);

  localparam int NQ        = mqmh_pkg::NUM_QUEUES;
  localparam int QW        = mqmh_pkg::QIDX_W;
  localparam int IW        = mqmh_pkg::ITEM_WIDTH;
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NQ * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int STEP_W    = $clog2(NQ + 1);
  localparam int SUM_W     = $clog2(MEM_DEPTH + 1);

  typedef enum logic [1:0] {IDLE, SCAN, POP, REPORT} state_t;

  state_t                          state;
  logic [PTR_W-1:0]                read_pointer  [NQ];
  logic [PTR_W-1:0]                write_pointer [NQ];
  logic [CNT_W-1:0]                fill_count    [NQ];
  logic [CNT_W-1:0]                capacity;
  logic [NQ-1:0]                   queue_enable;
  logic [mqmh_pkg::REQ_W-1:0]      req_type;
  logic [STEP_W-1:0]               step;
  logic                            pend_valid;
  logic [QW-1:0]                   pend_q;

  logic [IW-1:0]                   mem [MEM_DEPTH];
  logic [IW-1:0]                   rd_data;

  logic                            accept;
  logic [QW-1:0]                   put_q;
  logic                            put_enabled;
  logic                            put_full;
  logic                            wr_en;
  logic [ADDR_W-1:0]               wr_addr;
  logic [QW-1:0]                   scan_q;
  logic [ADDR_W-1:0]               rd_addr;
  logic                            scan_more;
  logic [NQ-1:0]                   eligible;
  logic [SUM_W-1:0]                sum;
  logic [mqmh_pkg::COUNT_W-1:0]    total;
  logic                            none_held;

  mqmh_pkg::scan_ctl_t             scan_ctl;
  logic                            best_valid;
  logic [QW-1:0]                   best_q;
  logic [IW-1:0]                   best_val;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(p) + CNT_W'(1);
    return (n >= cap) ? '0 : PTR_W'(n);
  endfunction

  function automatic logic [ADDR_W-1:0] slot(input logic [QW-1:0] q,
                                             input logic [PTR_W-1:0] p);
    return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
  endfunction

  function automatic logic [CNT_W-1:0] clamp_cap(input logic [mqmh_pkg::CFG_W-1:0] v);
    if (v == '0) return CNT_W'(1);
    else if (32'(v) > 32'(QUEUE_DEPTH)) return CNT_W'(QUEUE_DEPTH);
    else return CNT_W'(v);
  endfunction

  assign busy   = (state != IDLE);
  assign accept = start && !busy;

  assign put_q       = request.queue_index;
  assign put_enabled = queue_enable[put_q];
  assign put_full    = fill_count[put_q] >= capacity;
  assign wr_en       = accept && (request.req_type == mqmh_pkg::REQ_PUT) &&
                       put_enabled && !put_full;
  assign wr_addr     = slot(put_q, write_pointer[put_q]);

  assign scan_q    = step[QW-1:0];
  assign rd_addr   = slot(scan_q, read_pointer[scan_q]);
  assign scan_more = step < STEP_W'(NQ);

  always_comb begin
    sum = '0;
    for (int q = 0; q < NQ; q++) begin
      eligible[q] = queue_enable[q] && (fill_count[q] != '0);
      if (queue_enable[q]) sum = sum + SUM_W'(fill_count[q]);
    end
    none_held = (eligible == '0);
    total = (32'(sum) > 32'(mqmh_pkg::COUNT_MAX)) ?
            mqmh_pkg::COUNT_W'(mqmh_pkg::COUNT_MAX) : mqmh_pkg::COUNT_W'(sum);
  end

  assign scan_ctl.clear = (state == IDLE);
  assign scan_ctl.take  = (state == SCAN) && pend_valid;
  assign scan_ctl.q     = pend_q;

  mqmh_min_unit u_min (
    .clk        (clk),
    .rst        (rst),
    .ctl        (scan_ctl),
    .cand       (rd_data),
    .best_valid (best_valid),
    .best_q     (best_q),
    .best_val   (best_val)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= request.data_in;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      done         <= 1'b0;
      capacity     <= CNT_W'(QUEUE_DEPTH);
      queue_enable <= '1;
      step         <= '0;
      pend_valid   <= 1'b0;
      for (int q = 0; q < NQ; q++) begin
        read_pointer[q]  <= '0;
        write_pointer[q] <= '0;
        fill_count[q]    <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            req_type            <= request.req_type;
            result.data_out     <= '0;
            result.source_queue <= '0;
            result.status       <= mqmh_pkg::ST_OK;
            state               <= REPORT;
            case (request.req_type)
              mqmh_pkg::REQ_PUT: begin
                if (!put_enabled) begin
                  result.status <= mqmh_pkg::ST_DISABLED;
                end else if (put_full) begin
                  result.status <= mqmh_pkg::ST_OVERFLOW;
                end else begin
                  write_pointer[put_q] <= next_ptr(write_pointer[put_q], capacity);
                  fill_count[put_q]    <= fill_count[put_q] + CNT_W'(1);
                end
              end
              mqmh_pkg::REQ_GET, mqmh_pkg::REQ_REMOVE: begin
                step       <= '0;
                pend_valid <= 1'b0;
                state      <= SCAN;
              end
              mqmh_pkg::REQ_CLEAR: begin
                for (int q = 0; q < NQ; q++) begin
                  read_pointer[q]  <= '0;
                  write_pointer[q] <= '0;
                  fill_count[q]    <= '0;
                end
              end
              default: begin
                state <= REPORT;
              end
            endcase
          end
        end
        SCAN: begin
          pend_valid <= scan_more && eligible[scan_q];
          pend_q     <= scan_q;
          step       <= step + STEP_W'(1);
          if (!scan_more) begin
            state <= POP;
          end
        end
        POP: begin
          if (!best_valid) begin
            result.status <= mqmh_pkg::ST_NOTHING;
          end else begin
            read_pointer[best_q] <= next_ptr(read_pointer[best_q], capacity);
            fill_count[best_q]   <= fill_count[best_q] - CNT_W'(1);
            result.source_queue  <= best_q;
            result.data_out      <= (req_type == mqmh_pkg::REQ_GET) ? best_val : '0;
          end
          state <= REPORT;
        end
        REPORT: begin
          result.total_count <= total;
          result.all_empty   <= none_held;
          done               <= 1'b1;
          state              <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase

      if (cfg_we) begin
        case (cfg_index)
          mqmh_pkg::REG_CAPACITY: begin
            capacity <= clamp_cap(cfg_data);
            for (int q = 0; q < NQ; q++) begin
              read_pointer[q]  <= '0;
              write_pointer[q] <= '0;
              fill_count[q]    <= '0;
            end
          end
          mqmh_pkg::REG_ENABLE: begin
            queue_enable <= cfg_data[NQ-1:0];
          end
          default: begin
            queue_enable <= queue_enable;
          end
        endcase
      end
    end
  end

`ifndef SYNTH
  a_done_after_report: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == REPORT))
    else $error("result strobe without a report cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_nothing_is_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == mqmh_pkg::ST_NOTHING) |->
      (result.data_out == '0 && result.source_queue == '0))
    else $error("empty take returned a value");

  for (genvar g = 0; g < NQ; g++) begin : g_fill_chk
    a_fill_in_cap: assert property (@(posedge clk) disable iff (rst)
      fill_count[g] <= capacity)
      else $error("queue fill exceeds capacity");
  end
`endif

endmodule

`default_nettype wire

>>> hw/rtl/mqmh_min_unit.sv
// Shared compare unit for the minimum-head scan: one unsigned comparator and
// the best-so-far registers, fed one head word per cycle by the sequencer.
// Depends on mqmh_pkg.
`default_nettype none

module mqmh_min_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  mqmh_pkg::scan_ctl_t                 ctl,
  input  logic [mqmh_pkg::ITEM_WIDTH-1:0]     cand,
  output logic                                best_valid,
  output logic [mqmh_pkg::QIDX_W-1:0]         best_q,
  output logic [mqmh_pkg::ITEM_WIDTH-1:0]     best_val
);

  logic better;

  // strict less-than keeps the lowest queue on a tie
  assign better = !best_valid || (cand < best_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
    end else if (ctl.clear) begin
      best_valid <= 1'b0;
    end else if (ctl.take && better) begin
      best_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take && better && !ctl.clear) begin
      best_q   <= ctl.q;
      best_val <= cand;
    end
  end

endmodule

`default_nettype wire
